### rtl/core/mcva_pkg.sv
// mcva_pkg: shared types, command codes and the pitch/level scale table
// for the midi to cv voice allocator; depends on nothing
package mcva_pkg;

    localparam int MIDI_MAX     = 127;
    localparam int SCALE_MAX    = 2000;
    localparam int NOTE_W       = 7;
    localparam int CV_W         = 11;
    localparam int CHAN_W       = 4;
    localparam int SHOWN_SLOTS  = 4;
    localparam int REG_VOICE_MODE = 0;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_OTHER    = 2'd2,
        CMD_SPARE    = 2'd3
    } cmd_t;

    typedef logic [CV_W-1:0] cv_t;
    typedef cv_t scale_lut_t [2**NOTE_W];

    // floor(x * 2000 / 127) for every 7-bit input, built at elaboration
    function automatic scale_lut_t build_scale_lut();
        scale_lut_t lut;
        for (int i = 0; i < 2**NOTE_W; i++)
        begin
            lut[i] = CV_W'((i * SCALE_MAX) / MIDI_MAX);
        end
        return lut;
    endfunction

    localparam scale_lut_t SCALE_LUT = build_scale_lut();

    // one event as broadcast to every cell
    typedef struct packed {
        logic              strobe;
        logic              poly;
        cmd_t              cmd;
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] note;
        cv_t               pitch;
        cv_t               level;
    } event_t;

    // contents of one voice slot
    typedef struct packed {
        logic              active;
        logic [NOTE_W-1:0] note;
        cv_t               pitch;
        cv_t               level;
    } slot_t;

endpackage

### rtl/core/mcva_cell.sv
// mcva_cell: one voice slot of the allocator chain
// depends on mcva_pkg; passes the allocation token to the next cell
module mcva_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mcva_pkg::event_t ev,
    input  logic            pend_in,
    output logic            pend_out,
    output mcva_pkg::slot_t slot_next
);
    import mcva_pkg::*;

    slot_t slot_reg;
    logic  hit;
    logic  take;
    logic  chan_sel;
    logic  load;
    logic  clear;

    // poly mode: first free slot for note on, first matching active slot for note off
    always_comb
    begin
        hit = 1'b0;
        case (ev.cmd)
            CMD_NOTE_ON:  hit = !slot_reg.active;
            CMD_NOTE_OFF: hit = slot_reg.active && (slot_reg.note == ev.note);
            default:      hit = 1'b0;
        endcase
    end

    assign take     = ev.poly && pend_in && hit;
    assign pend_out = pend_in && !take;

    // channel mode: this slot is addressed by its channel number
    assign chan_sel = !ev.poly && (ev.chan == CHAN_W'(CELL_INDEX));

    assign load  = ev.strobe && (ev.cmd == CMD_NOTE_ON)
                   && (take || chan_sel);
    assign clear = ev.strobe && (ev.cmd == CMD_NOTE_OFF)
                   && (take || chan_sel);

    // next slot contents
    always_comb
    begin
        slot_next = slot_reg;
        if (load)
        begin
            slot_next.active = 1'b1;
            slot_next.note   = ev.note;
            slot_next.pitch  = ev.pitch;
            slot_next.level  = ev.level;
        end
        else if (clear)
        begin
            slot_next.active = 1'b0;
        end
    end

    // slot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

### rtl/core/midi_to_cv_voice_allocator.sv
// midi_to_cv_voice_allocator: top level, a chain of voice slot cells
// behind an apb register and a registered output word; uses mcva_pkg, mcva_cell
// output: the word for each accepted input word is captured in the output word register
// throughput: one word per cycle while the output side is ready; the cell
// chain resolves the first-free / first-match token within that cycle
// reset: asynchronous, clears voice_mode, all slots and the output valid
module midi_to_cv_voice_allocator #(
    parameter int VOICE_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: channel[3:0], note_number[10:4], note_velocity[17:11], zero fill
    input  logic [23:0] s_tdata,
    // s_tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: gate_bits[3:0], pitch_cv_0..3 [47:4], level_cv_0..3 [91:48], zero fill
    output logic [95:0] m_tdata
);
    import mcva_pkg::*;

    localparam int OUT_BITS = SHOWN_SLOTS * (1 + 2 * CV_W);

    logic                voice_mode_reg;
    logic                cfg_write;
    logic                accept;
    event_t              ev;
    logic [VOICE_COUNT:0] pend;
    slot_t               slot_nx [VOICE_COUNT];
    logic [SHOWN_SLOTS-1:0] gate_nx;
    cv_t                 pitch_nx [SHOWN_SLOTS];
    cv_t                 level_nx [SHOWN_SLOTS];
    logic [OUT_BITS-1:0] out_word;
    logic                m_tvalid_reg;
    logic [95:0]         m_tdata_reg;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'(REG_VOICE_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            voice_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'(REG_VOICE_MODE))
        begin
            prdata[0] = voice_mode_reg;
        end
    end

    // input handshake and event broadcast
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ev.strobe = accept;
        ev.poly   = voice_mode_reg;
        ev.cmd    = cmd_t'(s_tuser);
        ev.chan   = s_tdata[3:0];
        ev.note   = s_tdata[10:4];
        ev.pitch  = SCALE_LUT[s_tdata[10:4]];
        ev.level  = SCALE_LUT[s_tdata[17:11]];
    end

    // cell chain, token enters at slot 0
    assign pend[0] = 1'b1;

    for (genvar g = 0; g < VOICE_COUNT; g++)
    begin : g_cell
        mcva_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ev        (ev),
            .pend_in   (pend[g]),
            .pend_out  (pend[g+1]),
            .slot_next (slot_nx[g])
        );
    end

    // shown slots, missing ones read as off and zero
    for (genvar g = 0; g < SHOWN_SLOTS; g++)
    begin : g_show
        if (g < VOICE_COUNT)
        begin : g_live
            assign gate_nx[g]  = slot_nx[g].active;
            assign pitch_nx[g] = slot_nx[g].pitch;
            assign level_nx[g] = slot_nx[g].level;
        end
        else
        begin : g_none
            assign gate_nx[g]  = 1'b0;
            assign pitch_nx[g] = '0;
            assign level_nx[g] = '0;
        end
    end

    assign out_word = {level_nx[3], level_nx[2], level_nx[1], level_nx[0],
                       pitch_nx[3], pitch_nx[2], pitch_nx[1], pitch_nx[0],
                       gate_nx};

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= 96'(out_word);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### bench/tb.sv
// tb: self-checking bench for midi_to_cv_voice_allocator, channel and poly voice
// allocation under random stalls on both streams; depends on mcva_pkg and the rtl
`timescale 1ns / 100ps

module tb;
    import mcva_pkg::*;

    localparam logic MODE_CHANNEL = 1'b0;
    localparam logic MODE_POLY    = 1'b1;
    localparam int   STALL_LIMIT  = 5000;
    localparam int   VOICES       = 4;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata: channel[3:0], note_number[10:4], note_velocity[17:11], zero fill
    logic [23:0] s_tdata;
    // s_tuser: command[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata: gate_bits[3:0], pitch_cv_0..3 [47:4], level_cv_0..3 [91:48], zero fill
    logic [95:0] m_tdata;

    // shadow of the voice slots and the mode register
    logic              shadow_mode;
    logic              voice_on    [VOICES];
    logic [NOTE_W-1:0] voice_note  [VOICES];
    cv_t               voice_pitch [VOICES];
    cv_t               voice_level [VOICES];

    logic [95:0] voice_frames [$];

    int  failures;
    int  words_sent;
    int  results_seen;
    int  mode_writes;
    int  stall_cycles;
    int  rx_hold_len;
    bit  rx_steady;
    bit  tx_steady;

    midi_to_cv_voice_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cv_t scale_cv(logic [6:0] x);
        int product;
        product = int'(x) * 2000;
        return cv_t'(product / 127);
    endfunction

    // voice slots as one output word
    function automatic logic [95:0] pack_voices();
        logic [95:0] w;
        w = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            w[i]             = voice_on[i];
            w[4 + 11*i +: 11] = voice_pitch[i];
            w[48 + 11*i +: 11] = voice_level[i];
        end
        return w;
    endfunction

    // update the shadow slots for one accepted event and queue the word it yields
    task automatic allocate_voice(cmd_t cmd, logic [3:0] chan, logic [6:0] note,
                                  logic [6:0] vel);
        bit done;
        done = 0;
        if (shadow_mode == MODE_CHANNEL)
        begin
            if (chan < VOICES)
            begin
                if (cmd == CMD_NOTE_ON)
                begin
                    voice_on[chan]    = 1'b1;
                    voice_note[chan]  = note;
                    voice_pitch[chan] = scale_cv(note);
                    voice_level[chan] = scale_cv(vel);
                end
                else if (cmd == CMD_NOTE_OFF)
                    voice_on[chan] = 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (!done && cmd == CMD_NOTE_ON && !voice_on[i])
                begin
                    voice_on[i]    = 1'b1;
                    voice_note[i]  = note;
                    voice_pitch[i] = scale_cv(note);
                    voice_level[i] = scale_cv(vel);
                    done = 1;
                end
                else if (!done && cmd == CMD_NOTE_OFF && voice_on[i]
                         && voice_note[i] == note)
                begin
                    voice_on[i] = 1'b0;
                    done = 1;
                end
            end
        end
        voice_frames.push_back(pack_voices());
    endtask

    task automatic report_mismatch(string what, int want, int got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // send one event word; entered and left at a falling edge, valid left high
    task automatic send_event(cmd_t cmd, logic [3:0] chan, logic [6:0] note,
                              logic [6:0] vel);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {6'b0, vel, note, chan};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        allocate_voice(cmd, chan, note, vel);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (voice_frames.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(logic [2:0] addr, logic [31:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch("voice_mode readback", want, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // mode changes only once the block has drained
    task automatic set_voice_mode(logic [31:0] value);
        wait_for_results();
        apb_write(3'(4 * REG_VOICE_MODE), value);
        shadow_mode = value[0];
        mode_writes++;
        apb_read_check(3'(4 * REG_VOICE_MODE), {31'b0, value[0]});
    endtask

    function automatic cmd_t pick_cmd(int on_pct, int off_pct, int other_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < on_pct)
            return CMD_NOTE_ON;
        else if (r < on_pct + off_pct)
            return CMD_NOTE_OFF;
        else if (r < on_pct + off_pct + other_pct)
            return CMD_OTHER;
        return CMD_SPARE;
    endfunction

    // refresh words, extremes of note and velocity, ignored channels
    task automatic test_channel_directed();
        send_event(CMD_OTHER, 4'd0, 7'd0, 7'd0);
        send_event(CMD_SPARE, 4'd15, 7'd127, 7'd127);
        send_event(CMD_NOTE_ON, 4'd0, 7'd0, 7'd127);
        send_event(CMD_NOTE_ON, 4'd1, 7'd127, 7'd0);
        send_event(CMD_NOTE_ON, 4'd2, 7'd64, 7'd1);
        send_event(CMD_NOTE_ON, 4'd3, 7'd127, 7'd127);
        send_event(CMD_NOTE_ON, 4'd15, 7'd85, 7'd42);
        // note off keeps pitch and level on the output
        send_event(CMD_NOTE_OFF, 4'd2, 7'd0, 7'd0);
        send_event(CMD_NOTE_OFF, 4'd9, 7'd127, 7'd0);
    endtask

    // slots carry over from channel mode: 0, 1, 3 on, 2 off but holding note 64
    task automatic test_poly_directed();
        set_voice_mode(32'd1);
        send_event(CMD_NOTE_OFF, 4'd0, 7'd64, 7'd0);
        send_event(CMD_NOTE_ON, 4'd7, 7'd10, 7'd100);
        // all slots busy, dropped
        send_event(CMD_NOTE_ON, 4'd0, 7'd20, 7'd100);
        send_event(CMD_NOTE_OFF, 4'd0, 7'd10, 7'd0);
        send_event(CMD_NOTE_ON, 4'd0, 7'd127, 7'd5);
        // same note twice, first active slot goes first
        send_event(CMD_NOTE_OFF, 4'd3, 7'd127, 7'd0);
        send_event(CMD_NOTE_OFF, 4'd3, 7'd127, 7'd0);
        send_event(CMD_SPARE, 4'd0, 7'd0, 7'd0);
    endtask

    task automatic test_channel_random(int count);
        logic [3:0] chan;
        for (int n = 0; n < count; n++)
        begin
            chan = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3))
                                                : 4'($urandom_range(4, 15));
            send_event(pick_cmd(45, 35, 12), chan, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
        end
    endtask

    // small note pool so offs find their ons and slots fill up
    task automatic test_poly_random(int count);
        logic [6:0] pool [6];
        logic [6:0] note;
        foreach (pool[i])
            pool[i] = 7'($urandom_range(0, 127));
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 85)
                note = pool[$urandom_range(0, 5)];
            else
                note = 7'($urandom_range(0, 127));
            send_event(pick_cmd(40, 45, 8), 4'($urandom_range(0, 15)), note,
                       7'($urandom_range(0, 127)));
        end
    endtask

    // receiver holds off while the sender keeps offering, then sender drains
    task automatic test_backpressure();
        tx_steady   = 1;
        rx_hold_len = 300;
        for (int n = 0; n < 40; n++)
            send_event(pick_cmd(45, 40, 8), 4'($urandom_range(0, 15)),
                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        wait_for_results();
        tx_steady = 0;
    endtask

    // output side ready pattern
    initial
    begin : receiver
        int gap;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                m_tready = 1'b0;
                repeat (rx_hold_len) @(negedge clk);
                rx_hold_len = 0;
            end
            gap = rx_steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // compare every output word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        logic [95:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (voice_frames.size() == 0)
                report_mismatch("unexpected word, gate_bits", 0, m_tdata[3:0]);
            else
            begin
                want = voice_frames.pop_front();
                results_seen++;
                if (m_tdata[3:0] !== want[3:0])
                    report_mismatch("gate_bits", want[3:0], m_tdata[3:0]);
                for (int i = 0; i < VOICES; i++)
                begin
                    if (m_tdata[4 + 11*i +: 11] !== want[4 + 11*i +: 11])
                        report_mismatch($sformatf("pitch_cv_%0d", i),
                                        want[4 + 11*i +: 11], m_tdata[4 + 11*i +: 11]);
                    if (m_tdata[48 + 11*i +: 11] !== want[48 + 11*i +: 11])
                        report_mismatch($sformatf("level_cv_%0d", i),
                                        want[48 + 11*i +: 11], m_tdata[48 + 11*i +: 11]);
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("midi_to_cv_voice_allocator: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_OTHER;
        failures     = 0;
        words_sent   = 0;
        results_seen = 0;
        mode_writes  = 0;
        rx_hold_len  = 0;
        rx_steady    = 0;
        tx_steady    = 0;
        shadow_mode  = MODE_CHANNEL;
        for (int i = 0; i < VOICES; i++)
        begin
            voice_on[i]    = 1'b0;
            voice_note[i]  = '0;
            voice_pitch[i] = '0;
            voice_level[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_channel_directed();
        test_poly_directed();
        test_poly_random(300);
        test_backpressure();
        set_voice_mode(32'd0);
        test_channel_random(300);
        // upper bits are ignored, this one selects poly
        set_voice_mode(32'hFFFF_FFFF);
        rx_steady = 1;
        tx_steady = 1;
        test_poly_random(150);
        rx_steady = 0;
        tx_steady = 0;
        set_voice_mode(32'hFFFF_FFFE);
        test_channel_random(150);
        set_voice_mode(32'd1);
        test_poly_random(100);

        wait_for_results();
        repeat (4) @(negedge clk);
        $display("sent %0d midi events, checked %0d voice words across %0d mode writes",
                 words_sent, results_seen, mode_writes);
        $display("channel and poly allocation, full and unmatched cases, long output stall");
        if (failures == 0)
            $display("midi_to_cv_voice_allocator: match");
        else
            $display("midi_to_cv_voice_allocator: mismatch");
        $finish;
    end

endmodule

### midi_to_cv_voice_allocator.f
rtl/core/mcva_pkg.sv
rtl/core/mcva_cell.sv
rtl/core/midi_to_cv_voice_allocator.sv
bench/tb.sv
